### src/nmea_rmc_field_extractor_macros.svh
// assertion helpers, clocked on clk with arst_n disable
`ifndef NMEA_RMC_FIELD_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define NRMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/nrmc_pkg.sv
`default_nettype none
package nrmc_pkg;

	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
	localparam logic [2:0] TYPE_RMC     = 3'd2;

	localparam logic [4:0] FLD_TIME     = 5'd1;
	localparam logic [4:0] FLD_STATUS   = 5'd2;
	localparam logic [4:0] FLD_LAT      = 5'd3;
	localparam logic [4:0] FLD_LAT_DIR  = 5'd4;
	localparam logic [4:0] FLD_LON      = 5'd5;
	localparam logic [4:0] FLD_LON_DIR  = 5'd6;
	localparam logic [4:0] FLD_DATE     = 5'd9;
	localparam logic [4:0] SAT_MAX      = 5'd31;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam logic [2:0] HDR_LEN = 3'd6;
	localparam int         NUM_TAGS = 7;

	localparam logic [47:0] TAGS [NUM_TAGS] = '{
		"$GPTXT", "$GPRMC", "$GPVTG", "$GPGGA", "$GPGSA", "$GPGSV", "$GPGLL"
	};

	typedef struct packed {
		logic [2:0]  sentence_type;
		logic [4:0]  field_number;
		logic [63:0] field_text;
		logic [4:0]  text_length;
		logic        field_valid;
		logic        end_of_sentence;
	} result_t;

	function automatic logic [2:0] classify(input logic [47:0] hdr);
		logic [2:0] r;
		r = TYPE_UNKNOWN;
		for (int t = 0; t < NUM_TAGS; t++) begin
			if (hdr == TAGS[t]) begin
				r = 3'(t + 1);
			end
		end
		return r;
	endfunction

	function automatic logic field_kept(input logic [2:0] ltype, input logic [4:0] idx);
		logic k;
		unique case (idx) inside
			FLD_TIME, FLD_STATUS, FLD_LAT, FLD_LAT_DIR,
			FLD_LON, FLD_LON_DIR, FLD_DATE: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k && (ltype == TYPE_RMC);
	endfunction

endpackage
`default_nettype wire

### src/nrmc_byte_if.sv
`default_nettype none
interface nrmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

### src/nrmc_result_if.sv
`default_nettype none
interface nrmc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  sentence_type;
	logic [4:0]  field_number;
	logic [63:0] field_text;
	logic [4:0]  text_length;
	logic        field_valid;
	logic        end_of_sentence;

	modport source (output valid, output sentence_type, output field_number,
		output field_text, output text_length, output field_valid,
		output end_of_sentence, input ready);
	modport sink (input valid, input sentence_type, input field_number,
		input field_text, input text_length, input field_valid,
		input end_of_sentence, output ready);
endinterface
`default_nettype wire

### src/nmea_rmc_field_extractor.sv
// channel  dir  payload
// chars    in   data_byte[7:0]
// fields   out  sentence_type, field_number, field_text[63:0], text_length,
//                field_valid, end_of_sentence
//
// One byte per cycle sustained while no result is stalled; each byte passes the input
// register, then line tracker logic into the result register.
// A byte that yields no result is retired without touching the output side.
// arst_n clears line state and both valid flags; the block starts at a fresh line.
// A stalled result holds the tracker; chars.ready follows fields.ready combinationally.
`default_nettype none
module nmea_rmc_field_extractor #(
	parameter int FIELD_CHARS = 8
) (
	input  wire           clk,
	input  wire           arst_n,
	nrmc_byte_if.sink     chars,
	nrmc_result_if.source fields
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              produce;
	logic              free;
	logic              advance;
	nrmc_pkg::result_t result;

	assign advance = valid_s1 && (!produce || free);

	nrmc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	nrmc_line_tracker #(
		.FIELD_CHARS (FIELD_CHARS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.consume (advance),
		.byte_s1 (byte_s1),
		.produce (produce),
		.result  (result)
	);

	nrmc_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1 && produce),
		.result (result),
		.free   (free),
		.fields (fields)
	);

`include "nmea_rmc_field_extractor_macros.svh"

	`NRMC_ASSERT_NOW(a_kept_is_rmc, fields.valid && fields.field_valid,
		fields.sentence_type == nrmc_pkg::TYPE_RMC, "kept field on non-RMC line")

	`NRMC_ASSERT_NOW(a_unkept_zero, fields.valid && !fields.field_valid,
		fields.field_text == 64'd0 && fields.text_length == 5'd0,
		"unkept result carries text")

	`NRMC_ASSERT_NOW(a_kept_index, fields.valid && fields.field_valid,
		fields.field_number == nrmc_pkg::FLD_TIME ||
		fields.field_number == nrmc_pkg::FLD_STATUS ||
		fields.field_number == nrmc_pkg::FLD_LAT ||
		fields.field_number == nrmc_pkg::FLD_LAT_DIR ||
		fields.field_number == nrmc_pkg::FLD_LON ||
		fields.field_number == nrmc_pkg::FLD_LON_DIR ||
		fields.field_number == nrmc_pkg::FLD_DATE, "kept field index not in set")

	`NRMC_ASSERT_NEXT(a_stall_holds_track, valid_s1 && produce && !free,
		valid_s1 && $stable(byte_s1), "pending byte lost under output stall")

endmodule
`default_nettype wire

### src/nrmc_in_stage.sv
`default_nettype none
module nrmc_in_stage (
	input  wire        clk,
	input  wire        arst_n,
	nrmc_byte_if.sink  chars,
	input  wire        advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.data_byte;
		end
	end

endmodule
`default_nettype wire

### src/nrmc_line_tracker.sv
`default_nettype none
module nrmc_line_tracker #(
	parameter int FIELD_CHARS = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               consume,
	input  wire  [7:0]        byte_s1,
	output logic              produce,
	output nrmc_pkg::result_t result
);

	logic [47:0] header_q;
	logic [2:0]  hdr_cnt_q;
	logic [2:0]  line_type_q;
	logic [4:0]  field_idx_q;
	logic [63:0] text_q;
	logic [4:0]  char_cnt_q;

	logic [47:0] header_d;
	logic [2:0]  hdr_cnt_d;
	logic [2:0]  line_type_d;
	logic [4:0]  field_idx_d;
	logic [63:0] text_d;
	logic [4:0]  char_cnt_d;

	logic        is_eol;
	logic        is_comma;
	logic        kept;
	logic [5:0]  shamt;

	assign is_eol   = (byte_s1 == nrmc_pkg::CHAR_LF) || (byte_s1 == nrmc_pkg::CHAR_NUL);
	assign is_comma = (byte_s1 == nrmc_pkg::CHAR_COMMA);
	assign shamt    = {3'd7 - char_cnt_q[2:0], 3'b000};

	always_comb begin
		header_d    = header_q;
		hdr_cnt_d   = hdr_cnt_q;
		line_type_d = line_type_q;
		field_idx_d = field_idx_q;
		text_d      = text_q;
		char_cnt_d  = char_cnt_q;
		kept        = 1'b0;
		produce     = 1'b0;

		if (is_eol) begin
			kept        = nrmc_pkg::field_kept(line_type_q, field_idx_q);
			produce     = 1'b1;
			header_d    = '0;
			hdr_cnt_d   = '0;
			line_type_d = nrmc_pkg::TYPE_UNKNOWN;
			field_idx_d = '0;
			text_d      = '0;
			char_cnt_d  = '0;
		end else begin
			if (hdr_cnt_q < nrmc_pkg::HDR_LEN) begin
				header_d  = {header_q[39:0], byte_s1};
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_d == nrmc_pkg::HDR_LEN) begin
					line_type_d = nrmc_pkg::classify(header_d);
				end
			end
			if (is_comma) begin
				kept    = nrmc_pkg::field_kept(line_type_d, field_idx_q);
				produce = kept;
				if (field_idx_q != nrmc_pkg::SAT_MAX) begin
					field_idx_d = field_idx_q + 5'd1;
				end
				text_d     = '0;
				char_cnt_d = '0;
			end else begin
				if (32'(char_cnt_q) < FIELD_CHARS) begin
					text_d = text_q | ({56'd0, byte_s1} << shamt);
				end
				if (char_cnt_q != nrmc_pkg::SAT_MAX) begin
					char_cnt_d = char_cnt_q + 5'd1;
				end
			end
		end

		result.sentence_type   = is_eol ? line_type_q : line_type_d;
		result.field_number    = field_idx_q;
		result.field_text      = kept ? text_q : 64'd0;
		result.text_length     = kept ? char_cnt_q : 5'd0;
		result.field_valid     = kept;
		result.end_of_sentence = is_eol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= '0;
			hdr_cnt_q   <= '0;
			line_type_q <= nrmc_pkg::TYPE_UNKNOWN;
			field_idx_q <= '0;
			text_q      <= '0;
			char_cnt_q  <= '0;
		end else if (consume) begin
			header_q    <= header_d;
			hdr_cnt_q   <= hdr_cnt_d;
			line_type_q <= line_type_d;
			field_idx_q <= field_idx_d;
			text_q      <= text_d;
			char_cnt_q  <= char_cnt_d;
		end
	end

endmodule
`default_nettype wire

### src/nrmc_out_stage.sv
`default_nettype none
module nrmc_out_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  nrmc_pkg::result_t result,
	output logic              free,
	nrmc_result_if.source     fields
);

	logic              valid_q;
	nrmc_pkg::result_t data_q;

	assign free = !valid_q || fields.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= result;
		end
	end

	assign fields.valid           = valid_q;
	assign fields.sentence_type   = data_q.sentence_type;
	assign fields.field_number    = data_q.field_number;
	assign fields.field_text      = data_q.field_text;
	assign fields.text_length     = data_q.text_length;
	assign fields.field_valid     = data_q.field_valid;
	assign fields.end_of_sentence = data_q.end_of_sentence;

endmodule
`default_nettype wire

### tb/sv/nmea_rmc_field_extractor_test.sv
module nmea_rmc_field_extractor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHARS_KEPT = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 175;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [2:0] {
		ST_UNKNOWN, ST_TXT, ST_RMC, ST_VTG, ST_GGA, ST_GSA, ST_GSV, ST_GLL
	} sent_type_t;

	typedef struct packed {
		logic [7:0]        ch;
		logic              typed;
		nrmc_pkg::result_t want;
	} drow_t;

	localparam nrmc_pkg::result_t NO_RES = '0;

	localparam logic [47:0] TALKER_TAGS [7] = '{
		"$GPTXT", "$GPRMC", "$GPVTG", "$GPGGA", "$GPGSA", "$GPGSV", "$GPGLL"
	};

	localparam drow_t DIRECTED [23] = '{
		'{nrmc_pkg::CHAR_NUL, 1'b1,
			'{nrmc_pkg::TYPE_UNKNOWN, 5'd0, 64'd0, 5'd0, 1'b0, 1'b1}},
		'{8'hFF,      1'b0, NO_RES},
		'{nrmc_pkg::CHAR_LF, 1'b1,
			'{nrmc_pkg::TYPE_UNKNOWN, 5'd0, 64'd0, 5'd0, 1'b0, 1'b1}},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{"X",        1'b0, NO_RES},
		'{nrmc_pkg::CHAR_LF, 1'b1,
			'{nrmc_pkg::TYPE_UNKNOWN, 5'd6, 64'd0, 5'd0, 1'b0, 1'b1}},
		'{"$",        1'b0, NO_RES},
		'{"G",        1'b0, NO_RES},
		'{"P",        1'b0, NO_RES},
		'{"R",        1'b0, NO_RES},
		'{"M",        1'b0, NO_RES},
		'{"C",        1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{8'h80,      1'b0, NO_RES},
		'{8'h0D,      1'b0, NO_RES},
		'{nrmc_pkg::CHAR_COMMA, 1'b0, NO_RES},
		'{"A",        1'b0, NO_RES},
		'{nrmc_pkg::CHAR_LF, 1'b0, NO_RES}
	};

	logic clk;
	logic arst_n;

	nrmc_byte_if   chars();
	nrmc_result_if fields();

	nmea_rmc_field_extractor #(
		.FIELD_CHARS(CHARS_KEPT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.fields (fields)
	);

	// line tracker state
	logic [47:0] hdr_shift = '0;
	logic [2:0]  hdr_cnt = '0;
	sent_type_t  cur_type = ST_UNKNOWN;
	logic [4:0]  fld_idx = '0;
	logic [63:0] fld_text = '0;
	logic [4:0]  fld_len = '0;

	nrmc_pkg::result_t field_results [$];
	nrmc_pkg::result_t head_exp;
	logic [7:0]  line_bytes [$];
	int          mismatches = 0;
	int unsigned cycles = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	logic        hold_go = 1'b0;
	int unsigned hold_left = 0;

	function automatic sent_type_t tag_type(input logic [47:0] hdr);
		case (hdr)
			"$GPTXT": return ST_TXT;
			"$GPRMC": return ST_RMC;
			"$GPVTG": return ST_VTG;
			"$GPGGA": return ST_GGA;
			"$GPGSA": return ST_GSA;
			"$GPGSV": return ST_GSV;
			"$GPGLL": return ST_GLL;
			default:  return ST_UNKNOWN;
		endcase
	endfunction

	function automatic logic rmc_keeps();
		if (cur_type != ST_RMC) begin
			return 1'b0;
		end
		return fld_idx inside {nrmc_pkg::FLD_TIME, nrmc_pkg::FLD_STATUS, nrmc_pkg::FLD_LAT,
			nrmc_pkg::FLD_LAT_DIR, nrmc_pkg::FLD_LON, nrmc_pkg::FLD_LON_DIR,
			nrmc_pkg::FLD_DATE};
	endfunction

	function automatic nrmc_pkg::result_t field_beat(input logic keep, input logic eos);
		nrmc_pkg::result_t r;
		r = '0;
		r.sentence_type = cur_type;
		r.field_number = fld_idx;
		if (keep) begin
			r.field_text = fld_text;
			r.text_length = fld_len;
			r.field_valid = 1'b1;
		end
		r.end_of_sentence = eos;
		return r;
	endfunction

	// advances the line tracker by one byte; returns 1 when a result is due
	function automatic logic rmc_track(input logic [7:0] b, output nrmc_pkg::result_t r);
		logic keep;
		r = '0;
		if (b == nrmc_pkg::CHAR_LF || b == nrmc_pkg::CHAR_NUL) begin
			r = field_beat(rmc_keeps(), 1'b1);
			hdr_shift = '0;
			hdr_cnt = '0;
			cur_type = ST_UNKNOWN;
			fld_idx = '0;
			fld_text = '0;
			fld_len = '0;
			return 1'b1;
		end
		if (hdr_cnt < nrmc_pkg::HDR_LEN) begin
			hdr_shift = {hdr_shift[39:0], b};
			hdr_cnt = hdr_cnt + 3'd1;
			if (hdr_cnt == nrmc_pkg::HDR_LEN) begin
				cur_type = tag_type(hdr_shift);
			end
		end
		if (b == nrmc_pkg::CHAR_COMMA) begin
			keep = rmc_keeps();
			if (keep) begin
				r = field_beat(1'b1, 1'b0);
			end
			if (fld_idx != nrmc_pkg::SAT_MAX) begin
				fld_idx = fld_idx + 5'd1;
			end
			fld_text = '0;
			fld_len = '0;
			return keep;
		end
		if (int'(fld_len) < CHARS_KEPT) begin
			fld_text[63 - 8 * int'(fld_len) -: 8] = b;
		end
		if (fld_len != nrmc_pkg::SAT_MAX) begin
			fld_len = fld_len + 5'd1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(0, 19) == 0) begin
			c = 8'($urandom_range(128, 255));
		end else begin
			c = 8'($urandom_range(32, 126));
			if (c == nrmc_pkg::CHAR_COMMA) begin
				c = ".";
			end
		end
		return c;
	endfunction

	// appends one line (well-formed, mutated, short or noise) to line_bytes
	task automatic make_line();
		int          kind;
		int          nfld;
		int          flen;
		int          pos;
		logic [47:0] hdr;
		kind = $urandom_range(0, 99);
		if (kind >= 94) begin
			repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (kind >= 88) begin
			repeat ($urandom_range(0, 5)) line_bytes.push_back(field_char());
			line_bytes.push_back($urandom_range(0, 1) ? nrmc_pkg::CHAR_LF : nrmc_pkg::CHAR_NUL);
			return;
		end
		hdr = (kind < 60) ? "$GPRMC" : TALKER_TAGS[$urandom_range(0, 6)];
		if (kind >= 80) begin
			pos = $urandom_range(0, 5);
			hdr[8 * pos +: 8] = $urandom_range(0, 1) ? nrmc_pkg::CHAR_COMMA :
				8'($urandom_range(32, 126));
		end
		for (int k = 5; k >= 0; k--) begin
			line_bytes.push_back(hdr[8 * k +: 8]);
		end
		nfld = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(8, 13);
		repeat (nfld) begin
			line_bytes.push_back(nrmc_pkg::CHAR_COMMA);
			flen = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
			repeat (flen) line_bytes.push_back(field_char());
		end
		if ($urandom_range(0, 1) == 1) begin
			line_bytes.push_back(8'h0D);
		end
		line_bytes.push_back(($urandom_range(0, 6) == 0) ? nrmc_pkg::CHAR_NUL :
			nrmc_pkg::CHAR_LF);
	endtask

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic typed,
		input nrmc_pkg::result_t want);
		nrmc_pkg::result_t r;
		logic              due;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.data_byte <= b;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		due = rmc_track(b, r);
		if (typed) begin
			r = want;
		end
		if (due) begin
			field_results.push_back(r);
		end
		@(negedge clk);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls plus a single long hold-off
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		fields.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				fields.ready <= 1'b0;
				hold_left--;
			end else begin
				fields.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && fields.valid && fields.ready) begin
			if (field_results.size() == 0) begin
				$error("result beat with nothing expected: field_number %0d",
					fields.field_number);
				mismatches++;
			end else begin
				head_exp = field_results.pop_front();
				check_field("sentence_type", 64'(head_exp.sentence_type),
					64'(fields.sentence_type));
				check_field("field_number", 64'(head_exp.field_number),
					64'(fields.field_number));
				check_field("field_text", head_exp.field_text, fields.field_text);
				check_field("text_length", 64'(head_exp.text_length),
					64'(fields.text_length));
				check_field("field_valid", 64'(head_exp.field_valid),
					64'(fields.field_valid));
				check_field("end_of_sentence", 64'(head_exp.end_of_sentence),
					64'(fields.end_of_sentence));
			end
		end
	end

	initial begin
		int sent;
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.data_byte = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			send_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
					hold_go = 1'b1;
				end
				1: begin
					src_idle_pct = 73;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 73;
				end
				default: begin
					src_idle_pct = 17;
					sink_stall_pct = 17;
				end
			endcase
			sent = 0;
			while (sent < PHASE_BYTES) begin
				line_bytes.delete();
				make_line();
				foreach (line_bytes[i]) begin
					send_byte(line_bytes[i], 1'b0, NO_RES);
				end
				sent += line_bytes.size();
			end
		end
		chars.valid <= 1'b0;

		while (field_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
